>>> sv/vcsm_pkg.sv
// ----------------------------------------------------------------------------
// vcsm_pkg: shared definitions for the vowel-collapsed substring matcher
// Holds the pattern capacity, derived widths, command codes and the byte
// normalization helpers used by the top level.
// ----------------------------------------------------------------------------
package vcsm_pkg;

  // Pattern capacity in normalized bytes, and the widths that follow from it.
  localparam int PAT_MAX = 64;
  localparam int LEN_W   = $clog2(PAT_MAX + 1);
  localparam int CHAR_W  = 8;

  // Command codes carried in tuser.
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  // Lowercase vowels that collapse when repeated.
  localparam logic [CHAR_W-1:0] CH_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_E = 8'h65;
  localparam logic [CHAR_W-1:0] CH_I = 8'h69;
  localparam logic [CHAR_W-1:0] CH_O = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_U = 8'h75;
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

  // Control bundle handed from the sequencer to each cell.
  typedef struct packed {
    logic load;    // write the incoming byte into this cell
    logic clear;   // drop the partial-match bit
    logic step;    // advance the partial-match bit on a kept text byte
    logic active;  // this cell lies inside the stored pattern
    logic tail;    // this cell holds the final pattern byte
  } cell_ctrl_t;

  function automatic logic is_low_vowel(input logic [CHAR_W-1:0] c);
    return (c == CH_A) || (c == CH_E) || (c == CH_I) || (c == CH_O) || (c == CH_U);
  endfunction

  // A byte is kept unless it is a vowel repeating the previously kept byte.
  function automatic logic keep_byte(input logic [CHAR_W-1:0] c,
                                     input logic [CHAR_W-1:0] prev);
    return !(is_low_vowel(c) && (c == prev));
  endfunction

endpackage

>>> sv/vowel_collapsed_substring_match.sv
// ----------------------------------------------------------------------------
// vowel_collapsed_substring_match: streaming substring search
// Pattern bytes (tuser = 0) are normalized and loaded into a row of cells;
// text bytes (tuser = 1) are normalized and matched against the row.
// ----------------------------------------------------------------------------
// The block accepts one byte per clock cycle while s_tready is high,
// pattern or text alike: each of the PAT_MAX cells of the row compares its
// stored byte with the incoming text byte and takes its partial-match bit
// from its left neighbor in the same cycle. The single result appears on
// the master side in the cycle after the last text byte (tlast = 1) is
// accepted, and s_tready stays low only while a result waits to be taken.
// A pattern stays stored for any number of later texts; with no pattern the
// result reports found. Normalized patterns longer than PAT_MAX bytes flag
// pattern_overflow and never report found.
module vowel_collapsed_substring_match
  import vcsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Slave side.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_in
  input  logic       s_tuser,   // [0] command
  input  logic       s_tlast,   // last
  // Master side.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] found, [1] pattern_overflow, [7:2] zero
);

  logic              s_xfer;
  logic              acc_pat;
  logic              acc_text;
  logic [CHAR_W-1:0] char_in;

  logic [LEN_W-1:0]  pat_len;
  logic [CHAR_W-1:0] pat_prev;
  logic              pat_closed;
  logic              pat_over;
  logic [CHAR_W-1:0] text_prev;
  logic              match_seen;

  logic [LEN_W-1:0]  len_eff;
  logic [CHAR_W-1:0] prev_eff;
  logic              over_eff;
  logic              keep_pat;
  logic              keep_text;
  logic              clear_text;
  logic              store_ok;

  logic [LEN_W-1:0]  pat_len_next;
  logic [CHAR_W-1:0] pat_prev_next;
  logic              pat_over_next;

  cell_ctrl_t        ctrl [PAT_MAX];
  logic [PAT_MAX:0]  chain;
  logic [PAT_MAX-1:0] hits;
  logic [PAT_MAX-1:0] tails;
  logic              hit_now;
  logic              found_now;

  logic              out_found;
  logic              out_over;

  assign char_in  = s_tdata[CHAR_W-1:0];
  assign s_tready = !m_tvalid || m_tready;
  assign s_xfer   = s_tvalid && s_tready;
  assign acc_pat  = s_xfer && (s_tuser == CMD_PATTERN);
  assign acc_text = s_xfer && (s_tuser == CMD_TEXT);

  // A pattern byte after a closed pattern starts over from an empty pattern.
  always_comb begin
    if (pat_closed) begin
      len_eff  = '0;
      prev_eff = CH_NUL;
      over_eff = 1'b0;
    end else begin
      len_eff  = pat_len;
      prev_eff = pat_prev;
      over_eff = pat_over;
    end
  end

  assign keep_pat  = keep_byte(char_in, prev_eff);
  assign keep_text = keep_byte(char_in, text_prev);
  assign store_ok  = len_eff < LEN_W'(PAT_MAX);

  // Text progress is dropped on a new pattern and after each result.
  assign clear_text = (acc_pat && pat_closed) || (acc_text && s_tlast);

  // Next values of the pattern bookkeeping.
  always_comb begin
    pat_len_next  = len_eff;
    pat_prev_next = prev_eff;
    pat_over_next = over_eff;
    if (keep_pat) begin
      pat_prev_next = char_in;
      if (store_ok) begin
        pat_len_next = len_eff + LEN_W'(1);
      end else begin
        pat_over_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len    <= '0;
      pat_prev   <= CH_NUL;
      pat_closed <= 1'b1;
      pat_over   <= 1'b0;
    end else if (acc_pat) begin
      pat_len    <= pat_len_next;
      pat_prev   <= pat_prev_next;
      pat_over   <= pat_over_next;
      pat_closed <= s_tlast;
    end else if (acc_text) begin
      pat_closed <= 1'b1;
    end
  end

  // Text history and the sticky match flag.
  always_ff @(posedge clk) begin
    if (rst || clear_text) begin
      text_prev  <= CH_NUL;
      match_seen <= 1'b0;
    end else if (acc_text && keep_text) begin
      text_prev  <= char_in;
      match_seen <= match_seen || hit_now;
    end
  end

  // Row of cells; cell 0 always sees a matched empty prefix.
  assign chain[0] = 1'b1;

  for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
    assign ctrl[k].load   = acc_pat && keep_pat && (len_eff == LEN_W'(k));
    assign ctrl[k].clear  = clear_text;
    assign ctrl[k].step   = acc_text && keep_text;
    assign ctrl[k].active = LEN_W'(k) < pat_len;
    assign ctrl[k].tail   = pat_len == LEN_W'(k + 1);
    assign tails[k]       = ctrl[k].tail;

    vcsm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl[k]),
      .char_in   (char_in),
      .chain_in  (chain[k]),
      .chain_out (chain[k+1]),
      .hit       (hits[k])
    );
  end

  assign hit_now   = |hits;
  assign found_now = !pat_over && (match_seen || hit_now || (pat_len == '0));

  // Output register; a result is held until the master side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc_text && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_text && s_tlast) begin
      out_found <= found_now;
      out_over  <= pat_over;
    end
  end

  assign m_tdata = {6'b0, out_over, out_found};

  // An overflowed pattern never reports a match.
  a_over_not_found : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("found set together with pattern_overflow");

  // The stored length never exceeds the row.
  a_len_bound : assert property (@(posedge clk) disable iff (rst)
    pat_len <= LEN_W'(PAT_MAX))
    else $error("pattern length beyond capacity");

  // At most one cell is the pattern tail.
  a_one_tail : assert property (@(posedge clk) disable iff (rst)
    $onehot0(tails))
    else $error("more than one tail cell");

  // The final text byte always yields a result in the next cycle.
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    (acc_text && s_tlast) |=> m_tvalid)
    else $error("missing result after last text byte");

  // With an empty pattern, no cell holds a partial-match bit.
  a_idle_cells_clear : assert property (@(posedge clk) disable iff (rst)
    (pat_len == '0) |-> (chain[PAT_MAX:1] == '0))
    else $error("partial-match bit set with empty pattern");

endmodule

>>> sv/vcsm_cell.sv
// ----------------------------------------------------------------------------
// vcsm_cell: one position of the pattern
// Stores one normalized pattern byte and the partial-match bit for that
// position, taking the previous cell's bit as its chain input.
// ----------------------------------------------------------------------------
module vcsm_cell
  import vcsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [CHAR_W-1:0] char_in,
  input  logic              chain_in,
  output logic              chain_out,
  output logic              hit
);

  logic [CHAR_W-1:0] pat_byte;
  logic              match_bit;
  logic              match_bit_next;

  // The pattern byte needs no reset; it is only read once written.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pat_byte <= char_in;
    end
  end

  // The suffix of the text matches the pattern up to this position.
  assign match_bit_next = ctrl.active && chain_in && (pat_byte == char_in);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      match_bit <= 1'b0;
    end else if (ctrl.step) begin
      match_bit <= match_bit_next;
    end
  end

  assign chain_out = match_bit;

  // A full match completes when the tail cell sets its bit.
  assign hit = ctrl.tail && ctrl.step && match_bit_next;

endmodule
